/* design/apba_pkg.sv */
// Shared constants, types and helpers for the aligned page bitmap allocator.
package apba_pkg;

  localparam int unsigned PoolPages = 256;
  localparam int unsigned PageShift = 12;
  localparam int unsigned WordBits  = 32;
  localparam int unsigned BitIdxW   = $clog2(WordBits);
  localparam int unsigned Words     = (PoolPages + WordBits - 1) / WordBits;
  localparam int unsigned PageIdxW  = $clog2(PoolPages);
  localparam int unsigned WordIdxW  = (Words > 1) ? $clog2(Words) : 1;
  localparam int unsigned PgW       = PageIdxW + 2;
  localparam int unsigned PageNumW  = 32 - PageShift;

  typedef logic [PgW-1:0]      pg_t;
  typedef logic [WordIdxW-1:0] widx_t;
  typedef logic [WordBits-1:0] word_t;

  typedef enum logic [1:0] {
    StatusOk      = 2'd0,
    StatusBadSize = 2'd1,
    StatusNoSpace = 2'd2
  } status_e;

  typedef enum logic {
    ActAlloc = 1'b0,
    ActClear = 1'b1
  } action_e;

  typedef struct packed {
    logic  en;
    widx_t addr;
    word_t data;
  } bm_wr_t;

  function automatic widx_t word_of(pg_t p);
    pg_t t;
    t = p >> BitIdxW;
    return t[WordIdxW-1:0];
  endfunction

endpackage

/* design/apba_bitmap.sv */
// Page-used bitmap memory with registered read and a flash clear of all words.
module apba_bitmap (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            rd_en_i,
  input  apba_pkg::widx_t rd_addr_i,
  output apba_pkg::word_t rd_data_o,
  input  apba_pkg::bm_wr_t wr_i,
  input  logic            clr_i
);
  import apba_pkg::*;

  word_t            mem_q [Words];
  logic [Words-1:0] vld_q;
  word_t            rd_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  // unwritten words read as free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (clr_i) begin
        vld_q <= '0;
      end else if (wr_i.en) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

/* design/aligned_page_bitmap_allocator.sv */
// Aligned page bitmap allocator top level.
// Hands out naturally aligned regions from a window of PoolPages 4 KiB pages starting at the
// configured pool base; one used bit per page lives in a small bitmap RAM with a registered
// read. A clear transaction, or an allocate rejected for its size or with no aligned candidate
// inside the window, goes from the setup state straight to the result state, which loads the
// output register once that is free; the next transaction can be accepted after that. An
// allocate that searches also passes through the scan and mark states: the first-fit search
// steps through each candidate base, one 32-page word per cycle, then rewrites the words of
// the chosen span one per cycle. Single-page requests in a nearly full pool are the slowest case.
// One transaction is in work at a time; the next is accepted while a result is still waiting at
// the output register.
module aligned_page_bitmap_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [31:0] request_size_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [31:0] region_base_o
);
  import apba_pkg::*;

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StSetup  = 3'd1;
  localparam logic [2:0] StScan   = 3'd2;
  localparam logic [2:0] StMark   = 3'd3;
  localparam logic [2:0] StResult = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [PageNumW-1:0] pool_base_q;
  action_e             act_q, act_d;
  logic [31:0]         size_q, size_d;
  pg_t                 p_q, p_d;
  pg_t                 first_q, first_d;
  pg_t                 cnt_q, cnt_d;
  pg_t                 win_q, win_d;
  status_e             stat_q, stat_d;
  logic [31:0]         base_q, base_d;
  logic                out_valid_q, out_valid_d;
  status_e             out_status_q, out_status_d;
  logic [31:0]         out_base_q, out_base_d;

  logic                bm_rd_en;
  widx_t               bm_rd_addr;
  word_t               bm_rd_data;
  bm_wr_t              bm_wr;
  logic                bm_clr;

  apba_bitmap u_bitmap (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (bm_rd_en),
    .rd_addr_i (bm_rd_addr),
    .rd_data_o (bm_rd_data),
    .wr_i      (bm_wr),
    .clr_i     (bm_clr)
  );

  // request decode
  logic [PageNumW:0] room;
  pg_t               win;
  logic              pow2;
  logic              fits;
  pg_t               cnt;
  pg_t               off;

  always_comb begin
    room = {1'b1, {PageNumW{1'b0}}} - {1'b0, pool_base_q};
    win  = (room < (PageNumW+1)'(PoolPages)) ? pg_t'(room) : pg_t'(PoolPages);
    pow2 = (size_q != '0) && ((size_q & (size_q - 32'd1)) == '0);
    fits = {1'b0, size_q} <= 33'({win, {PageShift{1'b0}}});
    cnt  = (size_q[31:PageShift] == '0) ? pg_t'(1) : pg_t'(size_q[31:PageShift]);
    off  = (pg_t'(0) - pg_t'(pool_base_q)) & (cnt - pg_t'(1));
  end

  // span check against the word currently read
  pg_t   span_end;
  pg_t   boundary;
  word_t lo_mask;
  word_t hi_mask;
  word_t span_mask;
  logic  hit;
  logic  last;

  always_comb begin
    span_end  = first_q + cnt_q;
    boundary  = ((p_q >> BitIdxW) + pg_t'(1)) << BitIdxW;
    lo_mask   = ~((word_t'(1) << p_q[BitIdxW-1:0]) - word_t'(1));
    hi_mask   = (span_end < boundary) ?
                ((word_t'(1) << span_end[BitIdxW-1:0]) - word_t'(1)) : '1;
    span_mask = lo_mask & hi_mask;
    hit       = |(bm_rd_data & span_mask);
    last      = span_end <= boundary;
  end

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d      = state_q;
    act_d        = act_q;
    size_d       = size_q;
    p_d          = p_q;
    first_d      = first_q;
    cnt_d        = cnt_q;
    win_d        = win_q;
    stat_d       = stat_q;
    base_d       = base_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_base_d   = out_base_q;
    bm_rd_en     = 1'b0;
    bm_rd_addr   = '0;
    bm_wr        = '0;
    bm_clr       = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          act_d   = action_e'(action_i);
          size_d  = request_size_i;
          state_d = StSetup;
        end
      end
      StSetup: begin
        base_d = '0;
        if (act_q == ActClear) begin
          bm_clr  = 1'b1;
          stat_d  = StatusOk;
          state_d = StResult;
        end else if (!(pow2 && fits)) begin
          stat_d  = StatusBadSize;
          state_d = StResult;
        end else if ((off + cnt) > win) begin
          stat_d  = StatusNoSpace;
          state_d = StResult;
        end else begin
          first_d    = off;
          p_d        = off;
          cnt_d      = cnt;
          win_d      = win;
          bm_rd_en   = 1'b1;
          bm_rd_addr = word_of(off);
          state_d    = StScan;
        end
      end
      StScan: begin
        if (hit) begin
          if ((span_end + cnt_q) > win_q) begin
            stat_d  = StatusNoSpace;
            state_d = StResult;
          end else begin
            first_d    = span_end;
            p_d        = span_end;
            bm_rd_en   = 1'b1;
            bm_rd_addr = word_of(span_end);
          end
        end else if (last) begin
          p_d        = first_q;
          bm_rd_en   = 1'b1;
          bm_rd_addr = word_of(first_q);
          state_d    = StMark;
        end else begin
          p_d        = boundary;
          bm_rd_en   = 1'b1;
          bm_rd_addr = word_of(boundary);
        end
      end
      StMark: begin
        bm_wr.en   = 1'b1;
        bm_wr.addr = word_of(p_q);
        bm_wr.data = bm_rd_data | span_mask;
        if (last) begin
          stat_d  = StatusOk;
          base_d  = {pool_base_q + PageNumW'(first_q), {PageShift{1'b0}}};
          state_d = StResult;
        end else begin
          p_d        = boundary;
          bm_rd_en   = 1'b1;
          bm_rd_addr = word_of(boundary);
        end
      end
      StResult: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = stat_q;
          out_base_d   = base_q;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      pool_base_q <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        pool_base_q <= cfg_wdata_i[31:PageShift];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    act_q        <= act_d;
    size_q       <= size_d;
    p_q          <= p_d;
    first_q      <= first_d;
    cnt_q        <= cnt_d;
    win_q        <= win_d;
    stat_q       <= stat_d;
    base_q       <= base_d;
    out_status_q <= out_status_d;
    out_base_q   <= out_base_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign region_base_o = out_base_q;

  a_wr_clr_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(bm_wr.en && bm_clr))
    else $error("bitmap write and clear in the same cycle");

  a_rw_addr_differ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bm_rd_en && bm_wr.en) |-> (bm_rd_addr != bm_wr.addr))
    else $error("bitmap read and write hit the same word");

  a_err_base_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != StatusOk)) |-> (region_base_o == '0))
    else $error("non-zero region base with error status");

  a_cursor_in_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == StScan) || (state_q == StMark)) |->
      ((p_q >= first_q) && (p_q < (first_q + cnt_q))))
    else $error("page cursor outside candidate span");

endmodule

/* verif/tb.sv */
// Self-checking testbench for the aligned page bitmap allocator, with a cycle-free predictor.
`timescale 1ns / 100ps

module tb;
  import apba_pkg::*;

  typedef struct packed {
    action_e     act;
    logic [31:0] size;
  } req_t;

  typedef struct packed {
    status_e     st;
    logic [31:0] base;
  } grant_t;

  localparam logic [32:0] PageBytes = 33'd1 << PageShift;
  localparam logic [32:0] AddrTop   = 33'h1_0000_0000;
  localparam logic [32:0] PoolBytes = 33'(PoolPages) << PageShift;
  localparam int unsigned WatchLimit = 4000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned PhaseItems = 98;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        action_i = 1'b0;
  logic [31:0] request_size_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  status_o;
  logic [31:0] region_base_o;

  aligned_page_bitmap_allocator u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .request_size_i (request_size_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .region_base_o  (region_base_o)
  );

  logic [PoolPages-1:0] page_map = '0;
  logic [31:0]          win_base = '0;
  req_t                 req_q[$];
  grant_t               grant_q[$];
  int unsigned          err_cnt = 0;
  int unsigned          stall_cnt = 0;
  int unsigned          hold_req = 0;
  int unsigned          hold_ack = 0;
  int unsigned          hold_cnt = 0;
  bit                   calm = 1'b0;
  req_t                 next_req;
  grant_t               got_grant;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [32:0] window_end();
    logic [32:0] hi;
    hi = {1'b0, win_base} + PoolBytes;
    if (hi > AddrTop) hi = AddrTop;
    return hi;
  endfunction

  function automatic grant_t alloc_predict(action_e act, logic [31:0] size);
    grant_t      g;
    logic [32:0] lo, hi, sz, align, cand;
    int unsigned first, cnt;
    bit          fits;
    g.st = StatusOk;
    g.base = '0;
    if (act == ActClear) begin
      page_map = '0;
      return g;
    end
    lo = {1'b0, win_base};
    hi = window_end();
    sz = {1'b0, size};
    if (sz == 0 || (sz & (sz - 1)) != 0 || sz > hi - lo) begin
      g.st = StatusBadSize;
      return g;
    end
    align = (sz > PageBytes) ? sz : PageBytes;
    cnt = align >> PageShift;
    cand = (lo + align - 1) & ~(align - 1);
    while (cand + sz <= hi) begin
      first = (cand - lo) >> PageShift;
      if (first + cnt <= PoolPages) begin
        fits = 1'b1;
        for (int i = 0; i < cnt; i++) if (page_map[first + i]) fits = 1'b0;
        if (fits) begin
          for (int i = 0; i < cnt; i++) page_map[first + i] = 1'b1;
          g.base = cand[31:0];
          return g;
        end
      end
      cand = cand + align;
    end
    g.st = StatusNoSpace;
    return g;
  endfunction

  function automatic logic [31:0] pick_size();
    logic [32:0] win;
    int unsigned top, r;
    win = window_end() - {1'b0, win_base};
    top = 0;
    while ((33'd1 << (top + 1)) <= win) top++;
    r = $urandom_range(99);
    if (r < 3) return 32'd0;
    if (r < 7) return $urandom();
    if (r < 10) return 32'd1 << $urandom_range(31);
    if (r < 65) return 32'd1 << $urandom_range((top < 14) ? top : 14);
    return 32'd1 << $urandom_range(top);
  endfunction

  task automatic push_req(input action_e act, input logic [31:0] size);
    req_t r;
    r.act = act;
    r.size = size;
    req_q.push_back(r);
  endtask

  task automatic queue_random(input int unsigned n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 4) push_req(ActClear, $urandom());
      else push_req(ActAlloc, pick_size());
    end
  endtask

  // checked away from the rising edge so the driver's updates have settled
  task automatic wait_drained();
    while (req_q.size() != 0 || in_valid_i || grant_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_base(input logic [31:0] v);
    wait_drained();
    repeat (5) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    win_base = v & 32'hFFFF_F000;
    @(negedge clk_i);
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    if (err_cnt < 100) $display("mismatch %s: got %h, want %h", what, got, want);
    err_cnt++;
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      action_i <= 1'b0;
      request_size_i <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        grant_q.push_back(alloc_predict(action_e'(action_i), request_size_i));
      end
      if (!in_valid_i || in_ready_o) begin
        if (req_q.size() != 0 && (calm || $urandom_range(99) >= 29)) begin
          next_req = req_q.pop_front();
          in_valid_i <= 1'b1;
          action_i <= next_req.act;
          request_size_i <= next_req.size;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result receiver, with an occasional long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_cnt <= HoldCycles;
      out_ready_i <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= calm || ($urandom_range(99) >= 29);
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (grant_q.size() == 0) begin
        report("unexpected transaction", {30'd0, status_o}, '0);
      end else begin
        got_grant = grant_q.pop_front();
        if (status_o !== got_grant.st) report("status", {30'd0, status_o}, {30'd0, got_grant.st});
        if (region_base_o !== got_grant.base) report("region_base", region_base_o, got_grant.base);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stall_cnt <= 0;
      end else if (stall_cnt >= WatchLimit) begin
        $display("Some tests failed");
        $finish;
      end else begin
        stall_cnt <= stall_cnt + 1;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_base(32'h0000_0000);
    push_req(ActClear, 32'd0);
    push_req(ActAlloc, 32'd0);
    push_req(ActAlloc, 32'd1);
    push_req(ActAlloc, 32'h0000_1000);
    push_req(ActAlloc, 32'h0000_2000);
    push_req(ActAlloc, 32'd3);
    push_req(ActAlloc, 32'hFFFF_FFFF);
    push_req(ActAlloc, 32'h8000_0000);
    push_req(ActAlloc, 32'h0010_0000);
    push_req(ActClear, 32'd0);
    push_req(ActAlloc, 32'h0010_0000);
    push_req(ActAlloc, 32'd1);
    push_req(ActClear, 32'hFFFF_FFFF);

    // window clipped at the top of the address space
    write_base(32'hFFFF_FFFF);
    push_req(ActAlloc, 32'h0000_2000);
    push_req(ActAlloc, 32'h0000_1000);
    push_req(ActAlloc, 32'd1);

    // base not aligned to the request; page marks carried over
    write_base(32'h0000_3000);
    push_req(ActAlloc, 32'h0000_4000);
    push_req(ActAlloc, 32'h0000_1000);
    push_req(ActAlloc, 32'h0010_0000);

    write_base(32'h0000_0000);
    calm = 1'b1;
    queue_random(PhaseItems);
    wait_drained();
    calm = 1'b0;

    write_base($urandom());
    queue_random(PhaseItems);
    hold_req++;

    write_base(32'hFFF8_0000);
    queue_random(PhaseItems);

    write_base(32'hFFFF_F000);
    queue_random(PhaseItems);

    write_base(32'h0001_2FFF);
    queue_random(PhaseItems);
    hold_req++;

    write_base($urandom());
    queue_random(PhaseItems);

    write_base(32'h8000_0000);
    queue_random(PhaseItems);

    wait_drained();
    repeat (300) @(posedge clk_i);
    if (grant_q.size() != 0) report("missing transactions", grant_q.size(), '0);
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
